FILE: src/brsort_pkg.sv
// Shared types and constants for the two-stack binary radix sort unit.
// No dependencies; every other file in src imports this package.
package brsort_pkg;

	// Stack depth and the widths that follow from it
	localparam int MAX_ELEMENTS = 512;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int RANK_W       = 9;
	localparam int BIT_W        = 4;

	// Request modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_STEP = 1'b1;

	// Stack operation codes reported per step
	typedef enum logic [1:0] {
		OP_ROTATE = 2'd0,
		OP_PUSH_B = 2'd1,
		OP_PUSH_A = 2'd2,
		OP_NONE   = 2'd3
	} brsort_op_t;

	// One request
	typedef struct packed {
		logic              mode;
		logic [RANK_W-1:0] rank;
		logic              first;
	} brsort_item_t;

	// One result
	typedef struct packed {
		brsort_op_t operation;
		logic       done_res;
		logic       overflow;
	} brsort_result_t;

	// Stack store access for one cycle: one write and one read per stack
	typedef struct packed {
		logic              a_we;
		logic [ADDR_W-1:0] a_waddr;
		logic [RANK_W-1:0] a_wdata;
		logic [ADDR_W-1:0] a_raddr;
		logic              b_we;
		logic [ADDR_W-1:0] b_waddr;
		logic [RANK_W-1:0] b_wdata;
		logic [ADDR_W-1:0] b_raddr;
	} brsort_mem_req_t;

	// Top-of-stack values returned by the stores
	typedef struct packed {
		logic [RANK_W-1:0] top_a;
		logic [RANK_W-1:0] top_b;
	} brsort_tops_t;

endpackage

FILE: src/brsort_stacks.sv
// Storage for stacks A and B, with registered reads and write-to-read bypass.
// Depends on brsort_pkg for widths and the access structs.
module brsort_stacks
	import brsort_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  brsort_mem_req_t req,
	output brsort_tops_t    tops
);

	logic [RANK_W-1:0] a_mem [MAX_ELEMENTS];
	logic [RANK_W-1:0] b_mem [MAX_ELEMENTS];
	logic [RANK_W-1:0] a_rdata_q;
	logic [RANK_W-1:0] b_rdata_q;
	logic              a_byp_q;
	logic              b_byp_q;
	logic [RANK_W-1:0] a_byp_data_q;
	logic [RANK_W-1:0] b_byp_data_q;

	// Write and read stack A (read returns the old contents)
	always_ff @(posedge clk) begin
		if (req.a_we) begin
			a_mem[req.a_waddr] <= req.a_wdata;
		end
		a_rdata_q <= a_mem[req.a_raddr];
	end

	// Write and read stack B
	always_ff @(posedge clk) begin
		if (req.b_we) begin
			b_mem[req.b_waddr] <= req.b_wdata;
		end
		b_rdata_q <= b_mem[req.b_raddr];
	end

	// Catch a write to the address being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_byp_q <= 1'b0;
			b_byp_q <= 1'b0;
		end else begin
			a_byp_q <= req.a_we && (req.a_waddr == req.a_raddr);
			b_byp_q <= req.b_we && (req.b_waddr == req.b_raddr);
		end
	end

	always_ff @(posedge clk) begin
		a_byp_data_q <= req.a_wdata;
		b_byp_data_q <= req.b_wdata;
	end

	// Select fresh write data over the stale read
	assign tops.top_a = a_byp_q ? a_byp_data_q : a_rdata_q;
	assign tops.top_b = b_byp_q ? b_byp_data_q : b_rdata_q;

endmodule

FILE: src/brsort_core.sv
// Sort sequencer: stack pointers, pass state and the per-request decision.
// Depends on brsort_pkg; reads stack tops from brsort_stacks.
module brsort_core
	import brsort_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  brsort_item_t    item,
	input  brsort_tops_t    tops,
	output brsort_result_t  result,
	output brsort_mem_req_t mem_req
);

	logic [ADDR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0]  a_cnt_q, a_cnt_d;
	logic [CNT_W-1:0]  b_cnt_q, b_cnt_d;
	logic [RANK_W-1:0] largest_q, largest_d;
	logic [BIT_W-1:0]  bit_idx_q, bit_idx_d;
	logic [CNT_W-1:0]  progress_q, progress_d;
	logic              refill_q, refill_d;
	logic              finished_q, finished_d;

	// Circular slot arithmetic on stack A
	function automatic logic [ADDR_W-1:0] slot_after(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] offset);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
		if (sum >= (CNT_W+1)'(MAX_ELEMENTS)) begin
			sum = sum - (CNT_W+1)'(MAX_ELEMENTS);
		end
		return sum[ADDR_W-1:0];
	endfunction

	// Bit length of the largest rank, at least one
	function automatic logic [BIT_W-1:0] pass_total(input logic [RANK_W-1:0] r);
		logic [BIT_W-1:0] n;
		n = BIT_W'(1);
		for (int i = 1; i < RANK_W; i++) begin
			if (r[i]) begin
				n = BIT_W'(i + 1);
			end
		end
		return n;
	endfunction

	logic [ADDR_W-1:0]     ld_head;
	logic [CNT_W-1:0]      ld_a;
	logic [CNT_W-1:0]      ld_b;
	logic [RANK_W-1:0]     ld_large;
	logic [CNT_W:0]        total;
	logic                  examine;
	logic                  do_exam;
	logic [BIT_W-1:0]      eff_bit;
	logic [BIT_W-1:0]      bit_inc;
	logic [BIT_W-1:0]      passes;
	logic [2**BIT_W-1:0]   top_wide;
	logic [CNT_W-1:0]      b_dec;

	// Decide the next operation and the state it leaves
	always_comb begin
		head_d     = head_q;
		a_cnt_d    = a_cnt_q;
		b_cnt_d    = b_cnt_q;
		largest_d  = largest_q;
		bit_idx_d  = bit_idx_q;
		progress_d = progress_q;
		refill_d   = refill_q;
		finished_d = finished_q;

		mem_req.a_we    = 1'b0;
		mem_req.a_waddr = head_q;
		mem_req.a_wdata = tops.top_a;
		mem_req.b_we    = 1'b0;
		mem_req.b_waddr = b_cnt_q[ADDR_W-1:0];
		mem_req.b_wdata = tops.top_a;

		result.operation = OP_NONE;
		result.overflow  = 1'b0;

		ld_head  = item.first ? '0 : head_q;
		ld_a     = item.first ? '0 : a_cnt_q;
		ld_b     = item.first ? '0 : b_cnt_q;
		ld_large = item.first ? '0 : largest_q;
		total    = (CNT_W+1)'(ld_a) + (CNT_W+1)'(ld_b);
		examine  = !refill_q && ((CNT_W+1)'(progress_q) <
			((CNT_W+1)'(a_cnt_q) + (CNT_W+1)'(b_cnt_q))) && (a_cnt_q != '0);
		do_exam  = 1'b0;
		eff_bit  = bit_idx_q;
		bit_inc  = bit_idx_q + BIT_W'(1);
		passes   = pass_total(largest_q);
		top_wide = (2**BIT_W)'(tops.top_a);

		if (fire) begin
			if (item.mode == MODE_LOAD) begin
				if (total >= (CNT_W+1)'(MAX_ELEMENTS)) begin
					// Drop the load: stacks are full
					result.overflow = 1'b1;
				end else begin
					// Append the rank at the bottom of A and restart the sort
					mem_req.a_we    = 1'b1;
					mem_req.a_waddr = slot_after(ld_head, ld_a);
					mem_req.a_wdata = item.rank;
					head_d          = ld_head;
					a_cnt_d         = ld_a + CNT_W'(1);
					b_cnt_d         = ld_b;
					largest_d       = (item.rank > ld_large) ? item.rank : ld_large;
					bit_idx_d       = '0;
					progress_d      = '0;
					refill_d        = 1'b0;
					finished_d      = 1'b0;
				end
			end else if (!finished_q) begin
				if (examine) begin
					do_exam = 1'b1;
				end else if (b_cnt_q != '0) begin
					// Refill: move B's top back onto A
					head_d           = (head_q == '0) ? ADDR_W'(MAX_ELEMENTS - 1)
						: head_q - ADDR_W'(1);
					mem_req.a_we     = 1'b1;
					mem_req.a_waddr  = head_d;
					mem_req.a_wdata  = tops.top_b;
					b_cnt_d          = b_cnt_q - CNT_W'(1);
					a_cnt_d          = a_cnt_q + CNT_W'(1);
					refill_d         = 1'b1;
					result.operation = OP_PUSH_A;
				end else begin
					// End of pass: advance the bit, or finish
					bit_idx_d  = bit_inc;
					progress_d = '0;
					refill_d   = 1'b0;
					if (bit_inc >= passes) begin
						finished_d = 1'b1;
					end else if (a_cnt_q != '0) begin
						do_exam = 1'b1;
						eff_bit = bit_inc;
					end else begin
						// Empty set: run out the remaining passes at once
						bit_idx_d  = passes;
						finished_d = 1'b1;
					end
				end

				// Examine A's top: rotate on a one, push to B on a zero
				if (do_exam) begin
					progress_d = progress_d + CNT_W'(1);
					head_d     = slot_after(head_q, CNT_W'(1));
					if (top_wide[eff_bit]) begin
						mem_req.a_we     = 1'b1;
						mem_req.a_waddr  = slot_after(head_q, a_cnt_q);
						result.operation = OP_ROTATE;
					end else begin
						a_cnt_d          = a_cnt_q - CNT_W'(1);
						result.operation = OP_PUSH_B;
						if (b_cnt_q < CNT_W'(MAX_ELEMENTS)) begin
							mem_req.b_we = 1'b1;
							b_cnt_d      = b_cnt_q + CNT_W'(1);
						end
					end
				end
			end
		end

		result.done_res = finished_d;

		// Fetch the tops for the state this request leaves
		b_dec           = b_cnt_d - CNT_W'(1);
		mem_req.a_raddr = head_d;
		mem_req.b_raddr = b_dec[ADDR_W-1:0];
	end

	// Hold the sort state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			a_cnt_q    <= '0;
			b_cnt_q    <= '0;
			largest_q  <= '0;
			bit_idx_q  <= '0;
			progress_q <= '0;
			refill_q   <= 1'b0;
			finished_q <= 1'b0;
		end else begin
			head_q     <= head_d;
			a_cnt_q    <= a_cnt_d;
			b_cnt_q    <= b_cnt_d;
			largest_q  <= largest_d;
			bit_idx_q  <= bit_idx_d;
			progress_q <= progress_d;
			refill_q   <= refill_d;
			finished_q <= finished_d;
		end
	end

endmodule

FILE: src/binary_radix_sort_two_stacks_unit.sv
// Binary LSD radix sort on two stacks, at most one stack operation per request.
// A request enters an input register, is decided against the current tops of
// stacks A and B once the output register can take its result, and its result
// lands in that output register. One request is taken every cycle while the
// output is not stalled. That rate is set by the top-of-stack fetch,
// which reads each stack store every cycle at the pointers the previous
// request leaves, with a bypass for data written in that same cycle. Both
// stores hold 512 ranks and need no clearing after reset. A load past capacity
// returns overflow and changes nothing.
// Depends on brsort_pkg, brsort_stacks and brsort_core.
module binary_radix_sort_two_stacks_unit
	import brsort_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  brsort_item_t   item,
	output logic           result_valid,
	input  logic           result_stall,
	output brsort_result_t result
);

	logic            valid_s1;
	brsort_item_t    item_s1;
	logic            result_valid_q;
	brsort_result_t  result_q;
	logic            fire;
	brsort_result_t  core_result;
	brsort_mem_req_t mem_req;
	brsort_tops_t    tops;

	// Process the held request when the output register can take its result
	assign fire       = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= core_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	brsort_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.tops    (tops),
		.result  (core_result),
		.mem_req (mem_req)
	);

	brsort_stacks u_stacks (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.tops   (tops)
	);

endmodule

FILE: src/brsort_checker.sv
// Port-level checks for the two-stack radix sort unit, bound to the top level.
// Depends on brsort_pkg for the operation codes.
module brsort_checker
	import brsort_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	input logic           item_stall,
	input logic           result_valid,
	input logic           result_stall,
	input brsort_result_t result
);

	// A stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Requests back up only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("request stalled with output free");

	// A dropped load carries no stack operation
	a_overflow_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |-> result.operation == OP_NONE)
		else $error("overflow with a stack operation");

	// A real stack move never reports the sort finished
	a_move_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.operation != OP_NONE) |-> !result.done_res)
		else $error("stack operation reported as done");

endmodule

bind binary_radix_sort_two_stacks_unit brsort_checker u_brsort_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for binary_radix_sort_two_stacks_unit: directed and random
// load/step requests, with a predictor of the two-stack radix sort that checks every result.
// Depends on brsort_pkg and the unit under test in src.
module tb_top;
	import brsort_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int CYCLE_CAP  = 600000;
	localparam int LONG_HOLD  = 300;
	localparam int ITEM_GOAL  = 1800;
	localparam int SETTLE     = 8;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	brsort_item_t   item = '0;
	logic           result_valid;
	logic           result_stall = 1'b0;
	brsort_result_t result;

	// Predicted stack contents and sort progress
	logic [RANK_W-1:0] a_slots [MAX_ELEMENTS];
	logic [RANK_W-1:0] b_slots [MAX_ELEMENTS];
	logic [ADDR_W-1:0] a_top_slot = '0;
	logic [CNT_W-1:0]  a_fill = '0;
	logic [CNT_W-1:0]  b_fill = '0;
	logic [RANK_W-1:0] top_rank = '0;
	logic [BIT_W-1:0]  digit = '0;
	logic [CNT_W-1:0]  examined = '0;
	logic              draining_b = 1'b0;
	logic              sorted = 1'b0;

	brsort_result_t pending_results [$];

	// Sender and receiver pacing
	int  burst_left = 0;
	int  gap_max = 4;
	bit  no_gaps = 1'b1;
	int  stall_style = 0;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  stall_phase = 0;

	int  fail_count = 0;
	int  requests_sent = 0;
	int  results_checked = 0;
	int  overflows_seen = 0;
	int  sets_sorted = 0;
	int  cycle_count = 0;

	binary_radix_sort_two_stacks_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #CLK_HALF clk = ~clk;

	// Abort a run that stops making progress
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Bit length of the largest rank, at least one pass
	function automatic int unsigned pass_count(logic [RANK_W-1:0] r);
		int unsigned n = 1;
		while (r > 1) begin
			r >>= 1;
			n++;
		end
		return n;
	endfunction

	// Advance the predicted sort by one request and return the result it causes
	function automatic brsort_result_t next_sort_result(brsort_item_t req);
		brsort_result_t    res;
		logic [RANK_W-1:0] top;
		logic [ADDR_W-1:0] slot;
		res.operation = OP_NONE;
		res.overflow  = 1'b0;
		if (req.mode == MODE_LOAD) begin
			if (req.first) begin
				a_top_slot = '0;
				a_fill     = '0;
				b_fill     = '0;
				top_rank   = '0;
			end
			if (a_fill + b_fill >= MAX_ELEMENTS) begin
				res.overflow = 1'b1;
			end else begin
				slot = a_top_slot + a_fill[ADDR_W-1:0];
				a_slots[slot] = req.rank;
				a_fill++;
				if (req.rank > top_rank)
					top_rank = req.rank;
				digit      = '0;
				examined   = '0;
				draining_b = 1'b0;
				sorted     = 1'b0;
			end
		end else begin
			// Walk empty phases until a stack operation falls out or the sort ends
			while (!sorted && res.operation == OP_NONE) begin
				if (!draining_b && examined < a_fill + b_fill && a_fill != 0) begin
					top = a_slots[a_top_slot];
					examined++;
					a_top_slot++;
					if (((top >> digit) & 1) != 0) begin
						slot = a_top_slot + a_fill[ADDR_W-1:0] - 1'b1;
						a_slots[slot] = top;
						res.operation = OP_ROTATE;
					end else begin
						a_fill--;
						if (b_fill < MAX_ELEMENTS) begin
							b_slots[b_fill[ADDR_W-1:0]] = top;
							b_fill++;
						end
						res.operation = OP_PUSH_B;
					end
				end else if (!draining_b) begin
					draining_b = 1'b1;
				end else if (b_fill != 0) begin
					b_fill--;
					a_top_slot--;
					a_slots[a_top_slot] = b_slots[b_fill[ADDR_W-1:0]];
					a_fill++;
					res.operation = OP_PUSH_A;
				end else begin
					digit++;
					examined   = '0;
					draining_b = 1'b0;
					if (digit >= pass_count(top_rank))
						sorted = 1'b1;
				end
			end
		end
		res.done_res = sorted;
		return res;
	endfunction

	function automatic brsort_item_t make_req(logic mode, logic [RANK_W-1:0] rank, logic first);
		brsort_item_t req;
		req.mode  = mode;
		req.rank  = rank;
		req.first = first;
		return req;
	endfunction

	// Spread ranks over all magnitudes so the pass count varies
	function automatic logic [RANK_W-1:0] random_rank();
		return RANK_W'($urandom_range(0, 511) >> $urandom_range(0, 8));
	endfunction

	// Offer one request, in bursts with idle gaps, and predict on acceptance
	task automatic send_request(brsort_item_t req);
		int gap;
		bit ready;
		if (!no_gaps && burst_left == 0) begin
			gap = $urandom_range(1, gap_max);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left != 0)
			burst_left--;
		item       <= req;
		item_valid <= 1'b1;
		do begin
			@(negedge clk);
			ready = !item_stall;
			@(posedge clk);
		end while (!ready);
		pending_results.push_back(next_sort_result(req));
		requests_sent++;
	endtask

	// Drop valid and hold until every predicted result has been returned
	task automatic wait_for_results();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic step_until_sorted(int extra);
		while (!sorted)
			send_request(make_req(MODE_STEP, random_rank(), 1'($urandom_range(0, 1))));
		repeat (extra)
			send_request(make_req(MODE_STEP, random_rank(), 1'($urandom_range(0, 1))));
	endtask

	// Receiver: long hold-off on request, otherwise the current stall pattern
	always @(posedge clk) begin
		stall_phase++;
		if (hold_request) begin
			hold_left    = LONG_HOLD;
			hold_request = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (stall_style)
				1: begin
					result_stall <= ($urandom_range(0, 2) == 0);
				end
				2: begin
					result_stall <= (stall_phase % 8 >= 5);
				end
				3: begin
					result_stall <= ($urandom_range(0, 9) < 7);
				end
				default: begin
					result_stall <= 1'b0;
				end
			endcase
		end
	end

	// Compare each accepted result with the oldest prediction
	always begin
		brsort_result_t want;
		@(negedge clk);
		if (arst_n && result_valid && !result_stall) begin
			results_checked++;
			if (result.overflow)
				overflows_seen++;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: %p", result);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.operation !== want.operation) begin
					$error("operation: expected %0d, got %0d", want.operation, result.operation);
					fail_count++;
				end
				if (result.done_res !== want.done_res) begin
					$error("done_res: expected %0d, got %0d", want.done_res, result.done_res);
					fail_count++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0d, got %0d", want.overflow, result.overflow);
					fail_count++;
				end
			end
		end
	end

	// Steps on an empty set finish at once, then keep reporting done
	task automatic test_empty_set();
		no_gaps     = 1'b1;
		stall_style = 0;
		send_request(make_req(MODE_STEP, '0, 1'b0));
		send_request(make_req(MODE_STEP, '1, 1'b1));
	endtask

	// Largest and smallest ranks, a fresh set, and every stack operation
	task automatic test_extreme_ranks();
		stall_style = 2;
		send_request(make_req(MODE_LOAD, 9'd511, 1'b1));
		send_request(make_req(MODE_STEP, '0, 1'b0));
		send_request(make_req(MODE_STEP, '0, 1'b0));
		send_request(make_req(MODE_LOAD, 9'd0, 1'b1));
		send_request(make_req(MODE_LOAD, 9'd2, 1'b0));
		send_request(make_req(MODE_LOAD, 9'd1, 1'b0));
		step_until_sorted(1);
		sets_sorted++;
	endtask

	// Load arriving while stack B still holds elements
	task automatic test_load_mid_sort();
		no_gaps     = 1'b0;
		gap_max     = 3;
		stall_style = 1;
		send_request(make_req(MODE_LOAD, 9'd2, 1'b1));
		send_request(make_req(MODE_LOAD, 9'd0, 1'b0));
		send_request(make_req(MODE_STEP, '0, 1'b0));
		send_request(make_req(MODE_LOAD, 9'd3, 1'b0));
		step_until_sorted(1);
		sets_sorted++;
	endtask

	// Fill the stacks to their shared capacity under a long receiver hold-off, then overflow
	task automatic test_full_stacks();
		no_gaps     = 1'b1;
		stall_style = 0;
		wait_for_results();
		send_request(make_req(MODE_LOAD, random_rank(), 1'b1));
		hold_request = 1'b1;
		for (int i = 1; i < MAX_ELEMENTS; i++)
			send_request(make_req(MODE_LOAD, random_rank(), 1'b0));
		send_request(make_req(MODE_LOAD, 9'd7, 1'b0));
		repeat (4) send_request(make_req(MODE_STEP, '0, 1'b0));
		send_request(make_req(MODE_LOAD, 9'd300, 1'b0));
		send_request(make_req(MODE_LOAD, 9'd5, 1'b1));
		step_until_sorted(1);
		sets_sorted++;
	endtask

	// Mostly whole sets sorted to the end, with stray requests mixed in
	task automatic test_random_sets(int goal);
		int n;
		while (requests_sent < goal) begin
			gap_max     = $urandom_range(1, 6);
			no_gaps     = ($urandom_range(0, 3) == 0);
			stall_style = $urandom_range(0, 3);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 8))
					send_request(make_req(1'($urandom_range(0, 1)),
						RANK_W'($urandom_range(0, 511)), $urandom_range(0, 3) == 0));
			end else begin
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				send_request(make_req(MODE_LOAD, random_rank(), 1'b1));
				for (int i = 1; i < n; i++)
					send_request(make_req(MODE_LOAD, random_rank(), 1'b0));
				while (!sorted) begin
					if ($urandom_range(0, 49) == 0)
						send_request(make_req(MODE_LOAD, random_rank(), 1'b0));
					else
						send_request(make_req(MODE_STEP, random_rank(),
							1'($urandom_range(0, 1))));
				end
				sets_sorted++;
				repeat ($urandom_range(0, 2))
					send_request(make_req(MODE_STEP, random_rank(), 1'($urandom_range(0, 1))));
			end
			if ($urandom_range(0, 9) == 0)
				wait_for_results();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_set();
		test_extreme_ranks();
		test_load_mid_sort();
		test_full_stacks();
		test_random_sets(ITEM_GOAL);

		wait_for_results();
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d predicted results never returned", pending_results.size());
			fail_count++;
		end

		$display("Run covered %0d requests and %0d checked results: %0d sets sorted,",
			requests_sent, results_checked, sets_sorted);
		$display("%0d overflowing loads, one long receiver hold-off, %0d mismatches.",
			overflows_seen, fail_count);
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

FILE: files.f
src/brsort_pkg.sv
src/brsort_stacks.sv
src/brsort_core.sv
src/binary_radix_sort_two_stacks_unit.sv
src/brsort_checker.sv
sim/tb_top.sv
